// ----- rtl/hlcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared types, codes and helper functions of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package hlcd_pkg;

   // Input beat: one received byte or an end-of-chunk marker.
   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } req_type;

   // Output beat: one stray or frame byte.
   typedef struct packed {
      logic       kind;
      logic [7:0] byte_out;
      logic       last;
      logic       crc_ok;
   } rsp_type;

   // Up to two results written into the queue for one accepted item.
   // The second slot is only used together with the first.
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } q_wr_type;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic KIND_STRAY = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   localparam logic CSR_MIN_LEN = 1'b0;
   localparam logic CSR_MAX_LEN = 1'b1;

   localparam logic [7:0] MIN_LEN_RESET   = 8'd5;
   localparam logic [7:0] MAX_LEN_RESET   = 8'd128;
   localparam logic [7:0] FRAME_LEN_FLOOR = 8'd3;

   localparam logic [7:0] HDR_A = 8'hFA;
   localparam logic [7:0] HDR_B = 8'hFB;
   localparam logic [7:0] HDR_C = 8'hFC;

   // Reflected CRC-8/MAXIM polynomial.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   function automatic logic is_header(input logic [7:0] b);
      return (b == HDR_A) || (b == HDR_B) || (b == HDR_C);
   endfunction

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/hlcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcd_front
// Parser front end: holds framing state and configuration, classifies each
// accepted beat and writes its results into the result queue.
// ----------------------------------------------------------------------------
module hlcd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              req_valid,
   input  hlcd_pkg::req_type req_data,
   input  logic              room,
   output logic              req_ready,
   output hlcd_pkg::q_wr_type wr
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_BODY
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] min_len_ff, max_len_ff;
   logic [7:0] held_header_ff, held_header_in;
   logic [7:0] held_crc_ff, held_crc_in;
   logic [7:0] frame_len_ff, frame_len_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       accept;
   logic [7:0] b;
   logic [7:0] seen_next;
   logic       len_ok;
   hlcd_pkg::rsp_type r0, r1;
   logic       v0, v1;

   assign req_ready = room;
   assign accept    = req_valid && room;
   assign b         = req_data.data;
   assign seen_next = seen_ff + 8'd1;
   assign len_ok    = (b >= hlcd_pkg::FRAME_LEN_FLOOR) && (b >= min_len_ff)
                      && (b <= max_len_ff);

   always_comb begin
      phase_in       = phase_ff;
      held_header_in = held_header_ff;
      held_crc_in    = held_crc_ff;
      frame_len_in   = frame_len_ff;
      seen_in        = seen_ff;
      crc_in         = crc_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      v0 = 1'b0;
      v1 = 1'b0;
      r0 = '{kind: hlcd_pkg::KIND_STRAY, byte_out: pend_ff, last: 1'b0, crc_ok: 1'b0};
      r1 = '{kind: hlcd_pkg::KIND_FRAME, byte_out: b, last: 1'b0, crc_ok: 1'b0};
      if (req_data.op == hlcd_pkg::OP_FLUSH) begin
         // close the held stray run
         v0            = pend_valid_ff;
         r0.last       = 1'b1;
         pend_valid_in = 1'b0;
         pend_in       = '0;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               if (len_ok) begin
                  v0          = 1'b1;
                  v1          = 1'b1;
                  r0.kind     = hlcd_pkg::KIND_FRAME;
                  r0.byte_out = held_header_ff;
                  crc_in      = hlcd_pkg::crc8_step(held_crc_ff, b);
                  frame_len_in = b;
                  seen_in     = 8'd2;
                  phase_in    = PH_BODY;
               end else begin
                  // header becomes stray; no stray is held in this phase
                  v0          = 1'b1;
                  r0.byte_out = held_header_ff;
                  if (hlcd_pkg::is_header(b)) begin
                     r0.last        = 1'b1;
                     held_header_in = b;
                     held_crc_in    = hlcd_pkg::crc8_step(8'd0, b);
                     pend_valid_in  = 1'b0;
                     pend_in        = '0;
                  end else begin
                     pend_in       = b;
                     pend_valid_in = 1'b1;
                     phase_in      = PH_HUNT;
                  end
               end
            end
            PH_BODY: begin
               v0          = 1'b1;
               r0.kind     = hlcd_pkg::KIND_FRAME;
               r0.byte_out = b;
               if (seen_next >= frame_len_ff) begin
                  r0.last   = 1'b1;
                  r0.crc_ok = (crc_ff == b);
                  phase_in  = PH_HUNT;
                  seen_in   = '0;
                  crc_in    = '0;
               end else begin
                  crc_in  = hlcd_pkg::crc8_step(crc_ff, b);
                  seen_in = seen_next;
               end
            end
            default: begin
               v0 = pend_valid_ff;
               if (hlcd_pkg::is_header(b)) begin
                  r0.last        = 1'b1;
                  pend_valid_in  = 1'b0;
                  pend_in        = '0;
                  held_header_in = b;
                  held_crc_in    = hlcd_pkg::crc8_step(8'd0, b);
                  phase_in       = PH_LEN;
               end else begin
                  pend_in       = b;
                  pend_valid_in = 1'b1;
                  phase_in      = PH_HUNT;
               end
            end
         endcase
      end
   end

   assign wr.first_valid  = accept && v0;
   assign wr.second_valid = accept && v1;
   assign wr.first        = r0;
   assign wr.second       = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         min_len_ff     <= hlcd_pkg::MIN_LEN_RESET;
         max_len_ff     <= hlcd_pkg::MAX_LEN_RESET;
         held_header_ff <= '0;
         held_crc_ff    <= '0;
         frame_len_ff   <= '0;
         seen_ff        <= '0;
         crc_ff         <= '0;
         pend_ff        <= '0;
         pend_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == hlcd_pkg::CSR_MIN_LEN) begin
               min_len_ff <= csr_wdata;
            end else begin
               max_len_ff <= csr_wdata;
            end
         end
         if (accept) begin
            phase_ff       <= phase_in;
            held_header_ff <= held_header_in;
            held_crc_ff    <= held_crc_in;
            frame_len_ff   <= frame_len_in;
            seen_ff        <= seen_in;
            crc_ff         <= crc_in;
            pend_ff        <= pend_in;
            pend_valid_ff  <= pend_valid_in;
         end
      end
   end

endmodule

// ----- rtl/hlcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcd_queue
// Result queue: takes up to two results a cycle, hands out one a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module hlcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hlcd_pkg::q_wr_type            wr,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output hlcd_pkg::rsp_type             rsp_data,
   output logic                          room,
   output logic [$clog2(DEPTH+1)-1:0]    level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hlcd_pkg::rsp_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_plus1;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] push_n;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign wr_ptr_plus1 = ptr_inc(wr_ptr_ff);
   assign rsp_valid    = (count_ff != '0);
   assign rsp_data     = mem[rd_ptr_ff];
   assign pop          = rsp_valid && rsp_ready;
   assign room         = (count_ff <= CNT_W'(DEPTH - 2));
   assign level        = count_ff;
   assign push_n       = CNT_W'(wr.first_valid) + CNT_W'(wr.second_valid);
   assign count_in     = count_ff + push_n - CNT_W'(pop);
   assign rd_ptr_in    = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (wr.second_valid) begin
         wr_ptr_in = ptr_inc(wr_ptr_plus1);
      end else if (wr.first_valid) begin
         wr_ptr_in = wr_ptr_plus1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.first_valid) begin
         mem[wr_ptr_ff] <= wr.first;
      end
      if (wr.second_valid) begin
         mem[wr_ptr_plus1] <= wr.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/header_length_crc8_deframer.sv -----
`timescale 1ns / 1ps
// Each result of an accepted beat is queued and leaves on rsp as its own beat.
// Throughput: one req beat per cycle while the queue has room for two results;
//   rsp delivers one result per cycle from the queue while rsp_ready is high.
// Reset (synchronous, active high): hunting, no stray held, queue empty,
//   min_frame_len 5, max_frame_len 128.
// ----------------------------------------------------------------------------
// header_length_crc8_deframer
// Length-prefixed byte-stream deframer with CRC-8/MAXIM check on the last
// frame byte; bytes outside frames leave as stray runs.
// ----------------------------------------------------------------------------
module header_length_crc8_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   // configuration write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   // received beats
   input  logic              req_valid,
   output logic              req_ready,
   input  hlcd_pkg::req_type req_data,
   // deframed beats
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hlcd_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hlcd_pkg::q_wr_type q_wr;
   logic               q_room;
   logic [CNT_W-1:0]   q_level;

   // Configuration writes go straight into registers; never stall them.
   assign csr_ready = 1'b1;

   // Front end: track phase, length, CRC and the held stray byte. Stall
   // the input whenever the queue cannot take two more results.
   hlcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .room      (q_room),
      .req_ready (req_ready),
      .wr        (q_wr)
   );

   // Back end: buffer results and drain them one beat a cycle while rsp_ready
   // is high, so an rsp stall does not block intake until the queue fills.
   hlcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (q_wr),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .room      (q_room),
      .level     (q_level)
   );

   // Queue never overflows.
   assert property (@(posedge clock) disable iff (reset)
      q_level <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // A second result is only written alongside a first.
   assert property (@(posedge clock) disable iff (reset)
      q_wr.second_valid |-> q_wr.first_valid)
      else $error("second queue slot written alone");

   // CRC status only appears on the last byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.crc_ok) |->
         (rsp_data.kind == hlcd_pkg::KIND_FRAME) && rsp_data.last)
      else $error("crc_ok outside frame end");

   // An accepted beat writes results in the same cycle; the queue is
   // non-empty on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      q_wr.first_valid |=> rsp_valid)
      else $error("written result not visible");

endmodule
